// ===== design/vtdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity to drive command package
// Transfer types, register indexes, fixed-point constants and the CORDIC
// arctangent table shared by the drive command unit.
// ----------------------------------------------------------------------------
package vtdc_pkg;

  typedef struct packed {
    logic               present;
    logic               direct_mode;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate_in;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
  } out_t;

  localparam int unsigned CfgW    = 15;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegTurnRateLimit  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLinearStep     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAngularStep    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeadingDeadband = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinSpeed       = 3'd4;

  localparam logic [CfgW-1:0] TurnRateLimitRst   = 15'd4915;
  localparam logic [CfgW-1:0] LinearStepRst      = 15'd205;
  localparam logic [CfgW-1:0] AngularStepRst     = 15'd410;
  localparam logic [CfgW-1:0] HeadingDeadbandRst = 15'd819;
  localparam logic [CfgW-1:0] MinSpeedRst        = 15'd41;

  // Angles in Q3.13
  localparam logic signed [17:0] PiQ13     = 18'sd25736;
  localparam int unsigned        AtanSteps = 14;

  function automatic logic [12:0] atan_lut(input logic [3:0] idx);
    logic [12:0] val;
    case (idx)
      4'd0:    val = 13'd6434;
      4'd1:    val = 13'd3798;
      4'd2:    val = 13'd2007;
      4'd3:    val = 13'd1019;
      4'd4:    val = 13'd511;
      4'd5:    val = 13'd256;
      4'd6:    val = 13'd128;
      4'd7:    val = 13'd64;
      4'd8:    val = 13'd32;
      4'd9:    val = 13'd16;
      4'd10:   val = 13'd8;
      4'd11:   val = 13'd4;
      4'd12:   val = 13'd2;
      4'd13:   val = 13'd1;
      default: val = 13'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/velocity_to_drive_command_unit.sv =====
// Sequencing: a navigation item passes through the multiply, load, iterate,
// target and finish states; direct-mode and zero-vector items go to finish.
// Occupancy: one item at a time; a navigation item is held for the 16
// one-bit-per-cycle square root steps that also carry the CORDIC.
// Reset: asynchronous, active low; registers return to their defaults and the
// kept command levels to zero.
// ----------------------------------------------------------------------------
// Velocity to drive command unit
// Heading controller with bang-bang turn rate and slew-rate limited outputs,
// using a shared multiplier, a bit-serial square root and iterative CORDIC.
// ----------------------------------------------------------------------------
module velocity_to_drive_command_unit
  import vtdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_LOAD, ST_ITER, ST_TGT, ST_FIN
  } state_e;

  localparam int unsigned CW = 36;

  state_e state_q;
  in_t    in_q;
  logic [CfgW-1:0] trl_q, lstep_q, astep_q, db_q, minspd_q;
  logic signed [15:0] lin_lvl_q, ang_lvl_q, lin_t_q, ang_t_q;
  logic zero_q;
  logic [2:0] mul_step_q;
  logic signed [33:0] sq_q, num_q, den_q;
  logic [3:0] it_q;
  logic signed [CW-1:0] x_q [2];
  logic signed [CW-1:0] y_q [2];
  logic signed [17:0]   z_q [2];
  logic [1:0] zf_q;
  logic [31:0] rad_q;
  logic [17:0] rem_q;
  logic [15:0] root_q;
  logic        out_valid_q;
  out_t        out_q;

  // Shared multiplier
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;
  logic signed [33:0] prod_ext;

  always_comb begin
    unique case (mul_step_q)
      3'd0:    begin mul_a = in_q.vel_x;  mul_b = in_q.vel_x;  end
      3'd1:    begin mul_a = in_q.vel_y;  mul_b = in_q.vel_y;  end
      3'd2:    begin mul_a = in_q.quat_w; mul_b = in_q.quat_z; end
      3'd3:    begin mul_a = in_q.quat_x; mul_b = in_q.quat_y; end
      3'd4:    begin mul_a = in_q.quat_z; mul_b = in_q.quat_z; end
      default: begin mul_a = in_q.quat_y; mul_b = in_q.quat_y; end
    endcase
    prod     = mul_a * mul_b;
    prod_ext = 34'(prod);
  end

  // Lane set-up: lane 0 is the heading, lane 1 the yaw.
  logic signed [CW-1:0] ld_x [2];
  logic signed [CW-1:0] ld_y [2];
  logic signed [CW-1:0] ld_xr [2];
  logic signed [CW-1:0] ld_yr [2];
  logic signed [17:0]   ld_z [2];
  logic [1:0]           ld_zf;

  always_comb begin
    ld_x[0] = CW'(in_q.vel_x) <<< 16;
    ld_y[0] = CW'(in_q.vel_y) <<< 16;
    ld_x[1] = (CW'(1) <<< 28) - (CW'(den_q) <<< 1);
    ld_y[1] = CW'(num_q) <<< 1;
    ld_zf[0] = (in_q.vel_y == 16'sd0);
    ld_zf[1] = (ld_x[1] == '0) && (ld_y[1] == '0);
    for (int l = 0; l < 2; l++) begin
      if (ld_x[l] < 0) begin
        ld_z[l]  = (ld_y[l] >= 0) ? PiQ13 : -PiQ13;
        ld_xr[l] = -ld_x[l];
        ld_yr[l] = -ld_y[l];
      end else begin
        ld_z[l]  = '0;
        ld_xr[l] = ld_x[l];
        ld_yr[l] = ld_y[l];
      end
    end
  end

  // One CORDIC iteration per cycle on both lanes
  logic signed [CW-1:0] it_x [2];
  logic signed [CW-1:0] it_y [2];
  logic signed [CW-1:0] sh_x [2];
  logic signed [CW-1:0] sh_y [2];
  logic signed [17:0]   it_z [2];
  logic signed [17:0]   at;

  always_comb begin
    at = 18'(atan_lut(it_q));
    for (int l = 0; l < 2; l++) begin
      sh_x[l] = x_q[l] >>> it_q;
      sh_y[l] = y_q[l] >>> it_q;
      if (y_q[l] > 0) begin
        it_x[l] = x_q[l] + sh_y[l];
        it_y[l] = y_q[l] - sh_x[l];
        it_z[l] = z_q[l] + at;
      end else begin
        it_x[l] = x_q[l] - sh_y[l];
        it_y[l] = y_q[l] + sh_x[l];
        it_z[l] = z_q[l] - at;
      end
    end
  end

  // Restoring square root, one result bit per cycle
  logic [19:0] rem_ext, trial;
  logic        sq_ge;
  always_comb begin
    rem_ext = {rem_q, rad_q[31:30]};
    trial   = {2'b00, root_q, 2'b01};
    sq_ge   = rem_ext >= trial;
  end

  // Targets
  logic signed [17:0] ang_c [2];
  logic signed [17:0] diff, db_s, lim_s;
  logic [15:0]        spd_sat;
  logic signed [15:0] lin_tgt, ang_tgt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (zf_q[l])               ang_c[l] = '0;
      else if (z_q[l] > PiQ13)   ang_c[l] = PiQ13;
      else if (z_q[l] < -PiQ13)  ang_c[l] = -PiQ13;
      else                       ang_c[l] = z_q[l];
    end
    diff    = ang_c[1] - ang_c[0];
    db_s    = 18'(db_q);
    lim_s   = 18'(trl_q);
    spd_sat = root_q[15] ? 16'd32767 : root_q;
    lin_tgt = (spd_sat < 16'(minspd_q)) ? 16'sd0 : $signed(spd_sat);
    if (diff > db_s)
      ang_tgt = 16'((diff < PiQ13) ? -lim_s : lim_s);
    else if (diff < -db_s)
      ang_tgt = 16'((diff < -PiQ13) ? -lim_s : lim_s);
    else
      ang_tgt = 16'sd0;
  end

  function automatic logic signed [15:0] slew(input logic signed [15:0] tgt,
                                              input logic signed [15:0] lvl,
                                              input logic [CfgW-1:0] step);
    logic signed [17:0] t, v, up, dn, r;
    t  = 18'(tgt);
    v  = 18'(lvl);
    up = v + 18'(step);
    dn = v - 18'(step);
    if (t > v)      r = (up < t) ? up : t;
    else if (t < v) r = (dn > t) ? dn : t;
    else            r = t;
    return r[15:0];
  endfunction

  logic signed [15:0] lin_next, ang_next;
  logic               out_free, fin_go;
  always_comb begin
    lin_next = slew(lin_t_q, lin_lvl_q, lstep_q);
    ang_next = slew(ang_t_q, ang_lvl_q, astep_q);
    out_free = !out_valid_q || !out_stall_i;
    fin_go   = (state_q == ST_FIN) && out_free;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trl_q       <= TurnRateLimitRst;
      lstep_q     <= LinearStepRst;
      astep_q     <= AngularStepRst;
      db_q        <= HeadingDeadbandRst;
      minspd_q    <= MinSpeedRst;
      lin_lvl_q   <= '0;
      ang_lvl_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      in_q        <= '0;
      lin_t_q     <= '0;
      ang_t_q     <= '0;
      zero_q      <= 1'b0;
      mul_step_q  <= '0;
      sq_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      it_q        <= '0;
      zf_q        <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      for (int l = 0; l < 2; l++) begin
        x_q[l] <= '0;
        y_q[l] <= '0;
        z_q[l] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegTurnRateLimit:   trl_q    <= cfg_data_i;
          RegLinearStep:      lstep_q  <= cfg_data_i;
          RegAngularStep:     astep_q  <= cfg_data_i;
          RegHeadingDeadband: db_q     <= cfg_data_i;
          RegMinSpeed:        minspd_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && !fin_go) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_data_i.present) begin
            in_q       <= in_data_i;
            mul_step_q <= '0;
            zero_q     <= 1'b0;
            if (in_data_i.direct_mode) begin
              lin_t_q <= in_data_i.vel_x;
              ang_t_q <= in_data_i.turn_rate_in;
              state_q <= ST_FIN;
            end else if (in_data_i.vel_x == 16'sd0 && in_data_i.vel_y == 16'sd0) begin
              zero_q  <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          unique case (mul_step_q)
            3'd0:    sq_q  <= prod_ext;
            3'd1:    sq_q  <= sq_q + prod_ext;
            3'd2:    num_q <= prod_ext;
            3'd3:    num_q <= num_q + prod_ext;
            3'd4:    den_q <= prod_ext;
            default: den_q <= den_q + prod_ext;
          endcase
          mul_step_q <= mul_step_q + 3'd1;
          if (mul_step_q == 3'd5) state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int l = 0; l < 2; l++) begin
            x_q[l] <= ld_xr[l];
            y_q[l] <= ld_yr[l];
            z_q[l] <= ld_z[l];
          end
          zf_q    <= ld_zf;
          rad_q   <= sq_q[31:0];
          rem_q   <= '0;
          root_q  <= '0;
          it_q    <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          if (32'(it_q) < AtanSteps) begin
            for (int l = 0; l < 2; l++) begin
              x_q[l] <= it_x[l];
              y_q[l] <= it_y[l];
              z_q[l] <= it_z[l];
            end
          end
          rad_q <= {rad_q[29:0], 2'b00};
          if (sq_ge) begin
            rem_q  <= 18'(rem_ext - trial);
            root_q <= {root_q[14:0], 1'b1};
          end else begin
            rem_q  <= rem_ext[17:0];
            root_q <= {root_q[14:0], 1'b0};
          end
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) state_q <= ST_TGT;
        end
        ST_TGT: begin
          lin_t_q <= lin_tgt;
          ang_t_q <= ang_tgt;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (zero_q) begin
              out_q <= '0;
            end else begin
              out_q.linear_cmd  <= lin_next;
              out_q.angular_cmd <= ang_next;
              lin_lvl_q         <= lin_next;
              ang_lvl_q         <= ang_next;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic signed [17:0] lin_delta;
  assign lin_delta = 18'(lin_next) - 18'(lin_lvl_q);

`ifndef SYNTH
  a_slew_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && !zero_q) |-> (lin_delta <= $signed(18'(lstep_q)) &&
                             lin_delta >= -$signed(18'(lstep_q))))
    else $error("linear command moved by more than one step");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result appeared without a finishing cycle");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TGT) |-> (root_q <= 16'd46341))
    else $error("square root beyond largest possible speed");
`endif

endmodule
